// ----- sv/cccv_charger_pi_controller_core_assert.svh -----
// assertion macros used by the checker file
`ifndef CCCV_CHARGER_PI_CONTROLLER_CORE_ASSERT_SVH
`define CCCV_CHARGER_PI_CONTROLLER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define CCCV_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define CCCV_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/cccv_pkg.sv -----
package cccv_pkg;

	localparam int SAMPLE_WIDTH = 16;

	// reference path is at least as wide as the 16-bit voltage-loop clamp
	localparam int REF_W   = (SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16;
	localparam int ERR_W   = REF_W + 1;
	localparam int GAIN_W  = 16;
	localparam int PROD_W  = GAIN_W + 1 + ERR_W;
	localparam int ACC_W   = PROD_W + 1;
	localparam int INTEG_W = 32;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int DUTY_W    = 15;
	localparam int MODE_W    = 2;
	localparam int DSUM_W    = 19;

	localparam int V_SHIFT    = 12;
	localparam int C_SHIFT    = 6;
	localparam int RATIO_FRAC = 14;
	localparam int RATIO_W    = 16;
	localparam int RATIO_CAP  = 32768;
	localparam int DUTY_ONE   = 16384;

	localparam int NUM_W     = SAMPLE_WIDTH + RATIO_FRAC;
	localparam int DIV_CNT_W = $clog2(NUM_W + 1);

	localparam logic signed [ACC_W-1:0] ACC_INT_MAX =
		{{(ACC_W - INTEG_W + 1){1'b0}}, {(INTEG_W - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_INT_MIN =
		{{(ACC_W - INTEG_W + 1){1'b1}}, {(INTEG_W - 1){1'b0}}};

	localparam logic [MODE_W-1:0] MODE_IDLE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CC   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CV   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_KP_V    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KI_V    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VMAX    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KP_C    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_KI_C    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CMIN    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CMAX    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_END_CUR = 3'd7;

endpackage

// ----- sv/cccv_div.sv -----
module cccv_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [cccv_pkg::SAMPLE_WIDTH-1:0]   dividend,
	input  logic [cccv_pkg::SAMPLE_WIDTH-1:0]   divisor,
	output logic                                done,
	output logic [cccv_pkg::RATIO_W-1:0]        ratio
);
	import cccv_pkg::*;

	logic [NUM_W-1:0]        num_q;
	logic [SAMPLE_WIDTH-1:0] rem_q;
	logic [SAMPLE_WIDTH-1:0] den_q;
	logic [DIV_CNT_W-1:0]    cnt_q;
	logic                    busy_q;
	logic                    done_q;

	logic [SAMPLE_WIDTH:0] rem_sh;
	logic [SAMPLE_WIDTH:0] rem_sub;
	logic                  ge;

	// restoring division, one quotient bit per cycle shifted into num_q
	// a zero divisor yields all ones, which the cap below turns into 2.0
	assign rem_sh  = {rem_q, num_q[NUM_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {dividend, {RATIO_FRAC{1'b0}}};
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? rem_sub[SAMPLE_WIDTH-1:0] : rem_sh[SAMPLE_WIDTH-1:0];
		end
	end

	assign done  = done_q;
	assign ratio = (num_q > NUM_W'(RATIO_CAP)) ? RATIO_W'(RATIO_CAP) : num_q[RATIO_W-1:0];

endmodule

// ----- sv/cccv_charger_pi_controller_core.sv -----
// sequence: an idle-mode tick goes from transfer in through ST_FIN to the output register;
// a charging tick waits in ST_DIV on the bit-serial ratio divider started at transfer in,
// while one shared multiplier and adder step the cv-only voltage loop, then the current loop
// flow: one tick at a time; in_stall holds until out_stall lets the result register load
// reset: asynchronous active low; mode idle, integrators zero, registers at defaults
module cccv_charger_pi_controller_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [cccv_pkg::SAMPLE_WIDTH-1:0]   battery_voltage,
	input  logic [cccv_pkg::SAMPLE_WIDTH-1:0]   battery_current,
	input  logic [cccv_pkg::SAMPLE_WIDTH-1:0]   supply_voltage,
	input  logic [cccv_pkg::SAMPLE_WIDTH-1:0]   target_voltage,
	input  logic [cccv_pkg::SAMPLE_WIDTH-1:0]   target_current,
	input  logic                                charge_enable,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [cccv_pkg::DUTY_W-1:0]         duty,
	output logic [cccv_pkg::MODE_W-1:0]         mode,
	input  logic                                cfg_we,
	input  logic [cccv_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cccv_pkg::CFG_W-1:0]          cfg_data
);
	import cccv_pkg::*;

	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] ST_IDLE = 4'd0;
	localparam logic [ST_W-1:0] ST_VP   = 4'd1;
	localparam logic [ST_W-1:0] ST_VI   = 4'd2;
	localparam logic [ST_W-1:0] ST_VU   = 4'd3;
	localparam logic [ST_W-1:0] ST_CE   = 4'd4;
	localparam logic [ST_W-1:0] ST_CP   = 4'd5;
	localparam logic [ST_W-1:0] ST_CI   = 4'd6;
	localparam logic [ST_W-1:0] ST_CU   = 4'd7;
	localparam logic [ST_W-1:0] ST_DIV  = 4'd8;
	localparam logic [ST_W-1:0] ST_FIN  = 4'd9;

	logic [ST_W-1:0] state_q;

	logic [GAIN_W-1:0]        kp_voltage_q, ki_dt_voltage_q, voltage_loop_max_q;
	logic [GAIN_W-1:0]        kp_current_q, ki_dt_current_q, end_current_q;
	logic signed [CFG_W-1:0]  current_loop_min_q, current_loop_max_q;

	logic [MODE_W-1:0]         charge_mode_q;
	logic signed [INTEG_W-1:0] vi_q, ci_q;
	logic                      out_valid_q;
	logic [DUTY_W-1:0]         duty_out_q;

	logic [SAMPLE_WIDTH-1:0]  vb_q, ib_q, vt_q;
	logic                     en_q;
	logic [REF_W-1:0]         iref_q;
	logic signed [ERR_W-1:0]  err_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [CFG_W-1:0]  oc_q;
	logic [DUTY_W-1:0]        duty_q;

	logic                      accept;
	logic                      active_in;
	logic                      div_start;
	logic                      div_done;
	logic [RATIO_W-1:0]        div_ratio;
	logic [GAIN_W-1:0]         mul_gain;
	logic signed [PROD_W-1:0]  product;
	logic                      v_phase;
	logic signed [INTEG_W-1:0] integ_sel;
	logic signed [ACC_W-1:0]   acc;
	logic signed [ACC_W-1:0]   vo, co;
	logic [CFG_W-1:0]          vclamp;
	logic signed [CFG_W-1:0]   cclamp;
	logic signed [INTEG_W-1:0] acc_sat;
	logic signed [DSUM_W-1:0]  dsum;
	logic [DUTY_W-1:0]         dclamp;
	logic [MODE_W-1:0]         next_mode;
	logic                      out_free;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign active_in = (charge_mode_q == MODE_CC) || (charge_mode_q == MODE_CV);
	assign div_start = accept && active_in;
	assign out_free  = !out_valid_q || !out_stall;

	cccv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (battery_voltage),
		.divisor  (supply_voltage),
		.done     (div_done),
		.ratio    (div_ratio)
	);

	// shared multiplier: gain picked by sequencer step
	always_comb begin
		case (state_q)
			ST_VP:   mul_gain = kp_voltage_q;
			ST_VI:   mul_gain = ki_dt_voltage_q;
			ST_CP:   mul_gain = kp_current_q;
			ST_CI:   mul_gain = ki_dt_current_q;
			default: mul_gain = kp_current_q;
		endcase
	end
	assign product = $signed({1'b0, mul_gain}) * err_q;

	// shared adder: integrator plus registered product
	assign v_phase   = (state_q == ST_VI) || (state_q == ST_VU);
	assign integ_sel = v_phase ? vi_q : ci_q;
	assign acc       = ACC_W'(integ_sel) + ACC_W'(prod_q);

	assign vo = acc >>> V_SHIFT;
	assign co = acc >>> C_SHIFT;

	always_comb begin
		if (vo < 0)
			vclamp = '0;
		else if (vo > $signed(ACC_W'(voltage_loop_max_q)))
			vclamp = voltage_loop_max_q;
		else
			vclamp = vo[CFG_W-1:0];
	end

	// when the bounds cross, a value below the low bound takes the low bound, any other the high bound
	always_comb begin
		if (co < ACC_W'(current_loop_min_q))
			cclamp = current_loop_min_q;
		else if (co > ACC_W'(current_loop_max_q))
			cclamp = current_loop_max_q;
		else
			cclamp = co[CFG_W-1:0];
	end

	always_comb begin
		if (acc > ACC_INT_MAX)
			acc_sat = ACC_INT_MAX[INTEG_W-1:0];
		else if (acc < ACC_INT_MIN)
			acc_sat = ACC_INT_MIN[INTEG_W-1:0];
		else
			acc_sat = acc[INTEG_W-1:0];
	end

	// feedforward 1 - vb/vs plus loop term, saturated to [0, 1.0]
	assign dsum = DSUM_W'(DUTY_ONE) - $signed(DSUM_W'(div_ratio)) + DSUM_W'(oc_q);
	always_comb begin
		if (dsum < 0)
			dclamp = '0;
		else if (dsum > DSUM_W'(DUTY_ONE))
			dclamp = DUTY_W'(DUTY_ONE);
		else
			dclamp = dsum[DUTY_W-1:0];
	end

	always_comb begin
		case (charge_mode_q)
			MODE_CC: begin
				if (!en_q)
					next_mode = MODE_IDLE;
				else if (vb_q >= vt_q)
					next_mode = MODE_CV;
				else
					next_mode = MODE_CC;
			end
			MODE_CV: begin
				next_mode = MODE_CV;
				if (!en_q || (REF_W'(ib_q) <= REF_W'(end_current_q)))
					next_mode = MODE_IDLE;
				// falling below target re-enters cc even at end current
				if (en_q && (vb_q < vt_q))
					next_mode = MODE_CC;
			end
			default: begin
				if (!en_q)
					next_mode = MODE_IDLE;
				else if (vb_q < vt_q)
					next_mode = MODE_CC;
				else
					next_mode = MODE_CV;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_voltage_q       <= GAIN_W'(4096);
			ki_dt_voltage_q    <= GAIN_W'(410);
			voltage_loop_max_q <= GAIN_W'(65535);
			kp_current_q       <= GAIN_W'(4096);
			ki_dt_current_q    <= GAIN_W'(410);
			current_loop_min_q <= -CFG_W'(16384);
			current_loop_max_q <= CFG_W'(16384);
			end_current_q      <= GAIN_W'(77);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KP_V:    kp_voltage_q       <= cfg_data;
				CFG_KI_V:    ki_dt_voltage_q    <= cfg_data;
				CFG_VMAX:    voltage_loop_max_q <= cfg_data;
				CFG_KP_C:    kp_current_q       <= cfg_data;
				CFG_KI_C:    ki_dt_current_q    <= cfg_data;
				CFG_CMIN:    current_loop_min_q <= $signed(cfg_data);
				CFG_CMAX:    current_loop_max_q <= $signed(cfg_data);
				CFG_END_CUR: end_current_q      <= cfg_data;
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			charge_mode_q <= MODE_IDLE;
			vi_q          <= '0;
			ci_q          <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			// in ST_FIN the result register load below decides out_valid_q
			if (out_valid_q && !out_stall && (state_q != ST_FIN))
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (charge_mode_q == MODE_CV) begin
							state_q <= ST_VP;
						end else if (charge_mode_q == MODE_CC) begin
							vi_q    <= '0;
							state_q <= ST_CE;
						end else begin
							vi_q    <= '0;
							ci_q    <= '0;
							state_q <= ST_FIN;
						end
					end
				end
				ST_VP:  state_q <= ST_VI;
				ST_VI:  state_q <= ST_VU;
				ST_VU: begin
					vi_q    <= acc_sat;
					state_q <= ST_CE;
				end
				ST_CE:  state_q <= ST_CP;
				ST_CP:  state_q <= ST_CI;
				ST_CI:  state_q <= ST_CU;
				ST_CU: begin
					ci_q    <= acc_sat;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					// result register takes the transfer once it is free
					if (out_free) begin
						charge_mode_q <= next_mode;
						out_valid_q   <= 1'b1;
						if (next_mode == MODE_IDLE) begin
							vi_q <= '0;
							ci_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vb_q   <= battery_voltage;
			ib_q   <= battery_current;
			vt_q   <= target_voltage;
			en_q   <= charge_enable;
			iref_q <= REF_W'(target_current);
			err_q  <= $signed(ERR_W'(target_voltage) - ERR_W'(battery_voltage));
			duty_q <= '0;
		end
		case (state_q)
			ST_VP: prod_q <= product;
			ST_VI: begin
				prod_q <= product;
				iref_q <= REF_W'(vclamp);
			end
			ST_CE: err_q <= $signed(ERR_W'(iref_q) - ERR_W'(ib_q));
			ST_CP: prod_q <= product;
			ST_CI: begin
				prod_q <= product;
				oc_q   <= cclamp;
			end
			ST_DIV: begin
				if (div_done)
					duty_q <= dclamp;
			end
			ST_FIN: begin
				if (out_free)
					duty_out_q <= (next_mode == MODE_IDLE) ? '0 : duty_q;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign duty      = duty_out_q;
	// charge mode only moves when the result register loads, so it is the mode field
	assign mode      = charge_mode_q;

endmodule

// ----- sv/cccv_checker.sv -----
`include "cccv_charger_pi_controller_core_assert.svh"

module cccv_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [cccv_pkg::DUTY_W-1:0]    duty,
	input logic [cccv_pkg::MODE_W-1:0]    mode
);
	import cccv_pkg::*;

	// duty never exceeds full scale
	`CCCV_ASSERT_IMP(a_duty_range, out_valid, duty <= DUTY_W'(DUTY_ONE), "duty above 1.0")

	// an idle result always carries zero duty
	`CCCV_ASSERT_IMP(a_idle_zero, out_valid && (mode == MODE_IDLE), duty == '0, "idle duty not zero")

	// one tick at a time: input stalls right after a transfer
	`CCCV_ASSERT_NXT(a_busy_after_in, in_valid && !in_stall, in_stall, "input not stalled while busy")

	// a stalled result holds
	`CCCV_ASSERT_NXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(duty) && $stable(mode), "stalled result changed")

endmodule

bind cccv_charger_pi_controller_core cccv_checker u_cccv_checker (.*);

// ----- verif/cccv_charger_pi_controller_core_tb.sv -----
module cccv_charger_pi_controller_core_tb;
	import cccv_pkg::*;

	localparam int SW = SAMPLE_WIDTH;
	localparam longint SMAX = (64'sd1 <<< SW) - 1;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam longint INT32_HI = 64'sd2147483647;
	localparam longint INT32_LO = -64'sd2147483648;

	typedef struct packed {
		logic [SW-1:0] vbat;
		logic [SW-1:0] ibat;
		logic [SW-1:0] vsup;
		logic [SW-1:0] vtgt;
		logic [SW-1:0] itgt;
		logic          enable;
	} ctrl_sample_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic [MODE_W-1:0] mode;
	} pwm_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [SW-1:0]        battery_voltage;
	logic [SW-1:0]        battery_current;
	logic [SW-1:0]        supply_voltage;
	logic [SW-1:0]        target_voltage;
	logic [SW-1:0]        target_current;
	logic                 charge_enable;
	logic                 out_valid;
	logic                 out_stall;
	logic [DUTY_W-1:0]    duty;
	logic [MODE_W-1:0]    mode;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	cccv_charger_pi_controller_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.battery_voltage(battery_voltage),
		.battery_current(battery_current),
		.supply_voltage (supply_voltage),
		.target_voltage (target_voltage),
		.target_current (target_current),
		.charge_enable  (charge_enable),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.duty           (duty),
		.mode           (mode),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// charger model: settings and loop state as they stand after reset
	logic [CFG_W-1:0]  kp_v = 16'd4096;
	logic [CFG_W-1:0]  ki_v = 16'd410;
	logic [CFG_W-1:0]  vloop_max = 16'hFFFF;
	logic [CFG_W-1:0]  kp_c = 16'd4096;
	logic [CFG_W-1:0]  ki_c = 16'd410;
	shortint           c_lo = -16'sd16384;
	shortint           c_hi = 16'sd16384;
	logic [CFG_W-1:0]  end_cur = 16'd77;
	logic [MODE_W-1:0] model_mode = MODE_IDLE;
	int                volt_integ = 0;
	int                curr_integ = 0;

	pwm_result_t pwm_predictions[$];
	pwm_result_t oldest;
	int mismatches = 0;
	int results_seen = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int clip_int32(longint x);
		if (x > INT32_HI)
			return int'(INT32_HI);
		if (x < INT32_LO)
			return int'(INT32_LO);
		return int'(x);
	endfunction

	// one control tick: in cc or cv, pi loops, feedforward and duty saturation; then the mode decision
	function automatic pwm_result_t control_tick(ctrl_sample_t s);
		longint vb, ib, vs, vt, it, iref, err, term, ratio, d;
		logic [MODE_W-1:0] nxt;
		pwm_result_t r;
		vb = longint'(s.vbat);
		ib = longint'(s.ibat);
		vs = longint'(s.vsup);
		vt = longint'(s.vtgt);
		it = longint'(s.itgt);
		nxt = model_mode;
		d = 0;
		if (model_mode == MODE_CC || model_mode == MODE_CV) begin
			iref = it;
			if (model_mode == MODE_CV) begin
				err = vt - vb;
				term = (longint'(volt_integ) + longint'(kp_v) * err) >>> V_SHIFT;
				if (term < 0)
					term = 0;
				else if (term > longint'(vloop_max))
					term = longint'(vloop_max);
				volt_integ = clip_int32(longint'(volt_integ) + longint'(ki_v) * err);
				iref = term;
			end else begin
				volt_integ = 0;
			end
			err = iref - ib;
			term = (longint'(curr_integ) + longint'(kp_c) * err) >>> C_SHIFT;
			// when the bounds are crossed, a value below the lower bound takes it, any other the upper bound
			if (term < longint'(c_lo))
				term = longint'(c_lo);
			else if (term > longint'(c_hi))
				term = longint'(c_hi);
			curr_integ = clip_int32(longint'(curr_integ) + longint'(ki_c) * err);
			if (vs == 0) begin
				ratio = RATIO_CAP;
			end else begin
				ratio = (vb <<< RATIO_FRAC) / vs;
				if (ratio > RATIO_CAP)
					ratio = RATIO_CAP;
			end
			d = DUTY_ONE - ratio + term;
			if (d < 0)
				d = 0;
			else if (d > DUTY_ONE)
				d = DUTY_ONE;
			if (model_mode == MODE_CC) begin
				if (!s.enable)
					nxt = MODE_IDLE;
				else if (vb >= vt)
					nxt = MODE_CV;
			end else begin
				if (!s.enable || ib <= longint'(end_cur))
					nxt = MODE_IDLE;
				if (s.enable && vb < vt)
					nxt = MODE_CC;
			end
		end else begin
			volt_integ = 0;
			curr_integ = 0;
			if (s.enable)
				nxt = (vb < vt) ? MODE_CC : MODE_CV;
			else
				nxt = MODE_IDLE;
		end
		if (nxt == MODE_IDLE) begin
			d = 0;
			volt_integ = 0;
			curr_integ = 0;
		end
		model_mode = nxt;
		r.duty = DUTY_W'(d);
		r.mode = nxt;
		return r;
	endfunction

	function automatic ctrl_sample_t make_sample(int vb, int ib, int vs, int vt, int it, bit en);
		ctrl_sample_t s;
		s.vbat = SW'(vb);
		s.ibat = SW'(ib);
		s.vsup = SW'(vs);
		s.vtgt = SW'(vt);
		s.itgt = SW'(it);
		s.enable = en;
		return s;
	endfunction

	function automatic logic [SW-1:0] pick_sample();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return SW'($urandom_range(0, 255));
			default: return SW'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch on result %0d, %s: got %0d, expected %0d",
			results_seen, what, got, want);
		mismatches++;
	endtask

	task automatic send_tick(ctrl_sample_t s);
		in_valid <= 1'b1;
		battery_voltage <= s.vbat;
		battery_current <= s.ibat;
		supply_voltage <= s.vsup;
		target_voltage <= s.vtgt;
		target_current <= s.itgt;
		charge_enable <= s.enable;
		do
			@(posedge clk);
		while (in_stall);
		pwm_predictions.push_back(control_tick(s));
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	task automatic drain_block();
		in_valid <= 1'b0;
		wait (pwm_predictions.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// cfg_we is left high here so back-to-back writes need no second assignment per edge
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_KP_V: kp_v = val;
			CFG_KI_V: ki_v = val;
			CFG_VMAX: vloop_max = val;
			CFG_KP_C: kp_c = val;
			CFG_KI_C: ki_c = val;
			CFG_CMIN: c_lo = shortint'(val);
			CFG_CMAX: c_hi = shortint'(val);
			CFG_END_CUR: end_cur = val;
			default: ;
		endcase
	endtask

	task automatic apply_settings(logic [CFG_W-1:0] kpv, logic [CFG_W-1:0] kiv,
			logic [CFG_W-1:0] vmax, logic [CFG_W-1:0] kpc, logic [CFG_W-1:0] kic,
			logic [CFG_W-1:0] cmin, logic [CFG_W-1:0] cmax, logic [CFG_W-1:0] endc);
		drain_block();
		write_register(CFG_KP_V, kpv);
		write_register(CFG_KI_V, kiv);
		write_register(CFG_VMAX, vmax);
		write_register(CFG_KP_C, kpc);
		write_register(CFG_KI_C, kic);
		write_register(CFG_CMIN, cmin);
		write_register(CFG_CMAX, cmax);
		write_register(CFG_END_CUR, endc);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// one charge session: enable mostly high, battery mostly near target, ends with enable low
	task automatic run_session(int len);
		ctrl_sample_t s;
		longint level;
		s.vtgt = pick_sample();
		s.itgt = pick_sample();
		if ($urandom_range(0, 19) == 0)
			s.vsup = '0;
		else
			s.vsup = SW'($urandom_range(int'(s.vtgt), int'(SMAX)));
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(0, 9) == 0) begin
				s.vbat = pick_sample();
			end else begin
				level = longint'(s.vtgt) + $urandom_range(0, 800) - 400;
				s.vbat = SW'((level < 0) ? 0 : (level > SMAX) ? SMAX : level);
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					level = longint'(end_cur) + $urandom_range(1, 3000);
					s.ibat = SW'((level > SMAX) ? SMAX : level);
				end
				6, 7, 8: s.ibat = SW'($urandom_range(0, int'(end_cur)));
				default: s.ibat = pick_sample();
			endcase
			s.enable = (k != len - 1) && ($urandom_range(0, 29) != 0);
			send_tick(s);
		end
	endtask

	task automatic run_random(int n);
		int sent;
		int len;
		ctrl_sample_t s;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 99) < 15) begin
				s = make_sample(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
					pick_sample(), $urandom_range(0, 1));
				send_tick(s);
				sent++;
			end else begin
				len = $urandom_range(3, 40);
				if (len > n - sent)
					len = n - sent;
				run_session(len);
				sent += len;
			end
		end
	endtask

	task automatic test_mode_walk();
		send_idle_pct = 30;
		recv_idle_pct = 30;
		send_tick(make_sample(0, 0, 0, 0, 0, 0));
		send_tick(make_sample(65535, 65535, 65535, 65535, 65535, 0));
		// entering cc from idle gives zero duty
		send_tick(make_sample(16'h0C00, 16'h0100, 16'h1800, 16'h0D00, 16'h0200, 1));
		send_tick(make_sample(16'h0C00, 16'h0100, 16'h1800, 16'h0D00, 16'h0200, 1));
		send_tick(make_sample(16'h0C00, 16'hFFFF, 16'h1800, 16'h0D00, 16'h0200, 1));
		send_tick(make_sample(16'h0C00, 16'h0000, 16'h1800, 16'h0D00, 16'h0200, 1));
		// zero supply saturates the feedforward ratio
		send_tick(make_sample(16'h0C00, 16'h0100, 16'h0000, 16'h0D00, 16'h0200, 1));
		send_tick(make_sample(16'h0D00, 16'h0100, 16'h1800, 16'h0D00, 16'h0200, 1));
		send_tick(make_sample(16'h0D10, 16'h0100, 16'h1800, 16'h0D00, 16'h0200, 1));
		// end current reached but battery below target: back to cc, not idle
		send_tick(make_sample(16'h0C80, 16'd77, 16'h1800, 16'h0D00, 16'h0200, 1));
		send_tick(make_sample(16'h0D00, 16'h0100, 16'h1800, 16'h0D00, 16'h0200, 1));
		send_tick(make_sample(16'h0D20, 16'd77, 16'h1800, 16'h0D00, 16'h0200, 1));
		send_tick(make_sample(16'h0D20, 16'h0300, 16'h1800, 16'h0D00, 16'h0200, 1));
		send_tick(make_sample(16'h0D20, 16'h0300, 16'h1800, 16'h0D00, 16'h0200, 0));
		send_tick(make_sample(16'h0A00, 16'h0300, 16'h1800, 16'h0D00, 16'h0200, 1));
		send_tick(make_sample(16'h0A00, 16'h0300, 16'h1800, 16'h0D00, 16'h0200, 0));
		send_tick(make_sample(65535, 65535, 65535, 65535, 65535, 1));
		send_tick(make_sample(65535, 65535, 65535, 65535, 65535, 1));
		send_tick(make_sample(65535, 65535, 0, 65535, 0, 1));
		send_tick(make_sample(0, 0, 0, 0, 0, 1));
		send_tick(make_sample(0, 0, 0, 1, 0, 1));
		send_tick(make_sample(0, 0, 65535, 1, 65535, 1));
		send_tick(make_sample(65535, 0, 1, 1, 65535, 1));
		send_tick(make_sample(65535, 0, 1, 1, 65535, 0));
	endtask

	task automatic test_register_extremes();
		send_idle_pct = 20;
		recv_idle_pct = 20;
		apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF,
			16'hFFFF);
		run_random(100);
		apply_settings('0, '0, '0, '0, '0, '0, '0, '0);
		run_random(100);
		// crossed clamp bounds and a voltage integrator that saturates quickly
		apply_settings(16'hFFFF, 16'hFFFF, 16'd1000, 16'hFFFF, 16'd1, 16'h4000, 16'hC000,
			16'd0);
		run_random(100);
	endtask

	task automatic test_random_settings();
		for (int p = 0; p < 3; p++) begin
			send_idle_pct = (p == 0) ? 0 : 10 + 15 * p;
			recv_idle_pct = (p == 0) ? 0 : 55 - 15 * p;
			apply_settings(16'($urandom), 16'($urandom_range(0, 4096)), 16'($urandom),
				16'($urandom_range(0, 16384)), 16'($urandom_range(0, 4096)),
				16'(32'd0 - $urandom_range(0, 20000)), 16'($urandom_range(0, 20000)),
				16'($urandom_range(0, 1500)));
			run_random(200);
		end
	endtask

	task automatic test_streaming();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		apply_settings(16'd4096, 16'd410, 16'hFFFF, 16'd4096, 16'd410, 16'hC000, 16'h4000,
			16'd77);
		run_random(500);
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// compare every output transfer against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pwm_predictions.size() == 0) begin
				report_mismatch("result with nothing pending, duty", int'(duty), -1);
			end else begin
				oldest = pwm_predictions.pop_front();
				if (duty !== oldest.duty)
					report_mismatch("duty", int'(duty), int'(oldest.duty));
				if (mode !== oldest.mode)
					report_mismatch("mode", int'(mode), int'(oldest.mode));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				pwm_predictions.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		battery_voltage = '0;
		battery_current = '0;
		supply_voltage = '0;
		target_voltage = '0;
		target_current = '0;
		charge_enable = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_mode_walk();
		test_register_extremes();
		test_random_settings();
		test_streaming();
		drain_block();
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
